@@ rtl/core/wfp_pkg.sv @@
// Shared definitions for the wall-following PID steering block.
// Field widths, register map, register reset values and the structs that
// pass between the pipeline stages. No dependencies.
package wfp_pkg;

    // Field widths
    localparam int SAMPLE_W    = 10;
    localparam int SPEED_W     = 9;
    localparam int GAIN_W      = 18;
    localparam int BASE_W      = 9;
    localparam int OFFS_W      = 10;
    localparam int LEVEL_W     = 10;
    localparam int ERR_W       = 12;
    localparam int DERR_W      = ERR_W + 1;
    localparam int INTEG_W     = 24;
    localparam int FRAC_W      = 16;

    // Product widths: signed operand times unsigned gain (one extra sign bit)
    localparam int PTERM_W     = ERR_W + GAIN_W + 1;
    localparam int ITERM_W     = INTEG_W + GAIN_W + 1;
    localparam int DTERM_W     = DERR_W + GAIN_W + 1;
    localparam int FX_W        = ITERM_W + 3;
    localparam int Q_W         = FX_W - FRAC_W;

    localparam int SPEED_LIMIT = 255;
    localparam int RIGHT_TRIM  = 7;
    localparam int SAMPLES_DEF = 5;

    // Stream and configuration port widths
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 24;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 18;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN    = 4'd0,
        REG_INTEG_GAIN   = 4'd1,
        REG_DERIV_GAIN   = 4'd2,
        REG_BASE_SPEED   = 4'd3,
        REG_ERROR_OFFSET = 4'd4,
        REG_FRONT_LEVEL  = 4'd5,
        REG_WALL_LEVEL   = 4'd6,
        REG_OPEN_LEVEL   = 4'd7
    } reg_idx_t;

    typedef struct packed {
        logic        [GAIN_W-1:0]  prop_gain;
        logic        [GAIN_W-1:0]  integ_gain;
        logic        [GAIN_W-1:0]  deriv_gain;
        logic signed [BASE_W-1:0]  base_speed;
        logic signed [OFFS_W-1:0]  error_offset;
        logic        [LEVEL_W-1:0] front_level;
        logic        [LEVEL_W-1:0] wall_level;
        logic        [LEVEL_W-1:0] open_level;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        prop_gain:    18'd983,
        integ_gain:   18'd0,
        deriv_gain:   18'd983,
        base_speed:   9'sd25,
        error_offset: 10'sd25,
        front_level:  10'd500,
        wall_level:   10'd650,
        open_level:   10'd200
    };

    // Per-channel averages
    typedef struct packed {
        logic [SAMPLE_W-1:0] front;
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
    } avg_t;

    // Wall decision flags
    typedef struct packed {
        logic turn_right;
        logic turn_left;
        logic go_straight;
    } flags_t;

    // The three PID terms at 16 fraction bits
    typedef struct packed {
        logic signed [PTERM_W-1:0] prop_term;
        logic signed [ITERM_W-1:0] integ_term;
        logic signed [DTERM_W-1:0] deriv_term;
    } terms_t;

endpackage

@@ rtl/core/wall_follow_pid_steering.sv @@
// Top level of the wall-following PID steering block: configuration
// registers and the five-register pipeline. Depends on wfp_pkg, wfp_accum,
// wfp_divide, wfp_pid and wfp_drive.
//
// Usage:
//   s_ channel: one beat carries a front, left and right distance sample.
//   Every SAMPLES beats the block averages the three channels, runs the PID
//   and sends one beat on the m_ channel with both motor speeds and the
//   turn right / turn left / go straight flags. Other beats give no result.
//   cfg_ channel: cfg_addr selects a register (0 prop_gain .. 7 open_level),
//   cfg_wdata carries the value; cfg_ready is always high. Write only while
//   no result is pending. Writes to other indexes are dropped.
//   Throughput: one input beat per cycle, steady state. The result appears
//   on m_tvalid after the closing sample has passed the sum register, which
//   loads on the edge that accepts it, then the average, error, product and
//   output registers. The integral and previous error are each a single register
//   fed back to itself, so results may follow back to back even with SAMPLES = 1.
//   Stall: when m_tready is low, each stage holds its beat; the block keeps
//   taking samples until a closing sample finds the sum register full and
//   blocked, then drops s_tready.
//   Reset (aresetn low, synchronous): registers return to their defaults,
//   sums, sample count, integral and previous error clear, the pipeline
//   empties.
module wall_follow_pid_steering #(
    parameter int SAMPLES = wfp_pkg::SAMPLES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata: front_sample[9:0], left_sample[19:10], right_sample[29:20], zero pad
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [wfp_pkg::S_TDATA_W-1:0]    s_tdata,
    // m_tdata: left_speed[8:0], right_speed[17:9], turn_right[18], turn_left[19],
    //          go_straight[20], zero pad
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [wfp_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [wfp_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [wfp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import wfp_pkg::*;

    localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES);

    cfg_t                      cfg_reg;

    logic                      sum_valid, sum_ready;
    logic [SUM_W-1:0]          front_sum, left_sum, right_sum;
    logic                      avg_valid, avg_ready;
    avg_t                      avg;
    logic                      terms_valid, terms_ready;
    terms_t                    terms;
    flags_t                    flags;
    logic signed [SPEED_W-1:0] left_speed, right_speed;
    flags_t                    out_flags;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                REG_PROP_GAIN:    cfg_reg.prop_gain    <= cfg_wdata[GAIN_W-1:0];
                REG_INTEG_GAIN:   cfg_reg.integ_gain   <= cfg_wdata[GAIN_W-1:0];
                REG_DERIV_GAIN:   cfg_reg.deriv_gain   <= cfg_wdata[GAIN_W-1:0];
                REG_BASE_SPEED:   cfg_reg.base_speed   <= $signed(cfg_wdata[BASE_W-1:0]);
                REG_ERROR_OFFSET: cfg_reg.error_offset <= $signed(cfg_wdata[OFFS_W-1:0]);
                REG_FRONT_LEVEL:  cfg_reg.front_level  <= cfg_wdata[LEVEL_W-1:0];
                REG_WALL_LEVEL:   cfg_reg.wall_level   <= cfg_wdata[LEVEL_W-1:0];
                REG_OPEN_LEVEL:   cfg_reg.open_level   <= cfg_wdata[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline
    wfp_accum #(
        .SAMPLES (SAMPLES)
    ) u_accum (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .front_sample (s_tdata[SAMPLE_W-1:0]),
        .left_sample  (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .right_sample (s_tdata[3*SAMPLE_W-1:2*SAMPLE_W]),
        .sum_valid    (sum_valid),
        .sum_ready    (sum_ready),
        .front_sum    (front_sum),
        .left_sum     (left_sum),
        .right_sum    (right_sum)
    );

    wfp_divide #(
        .SAMPLES (SAMPLES)
    ) u_divide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready),
        .front_sum (front_sum),
        .left_sum  (left_sum),
        .right_sum (right_sum),
        .avg_valid (avg_valid),
        .avg_ready (avg_ready),
        .avg       (avg)
    );

    wfp_pid u_pid (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .avg_valid   (avg_valid),
        .avg_ready   (avg_ready),
        .avg         (avg),
        .terms_valid (terms_valid),
        .terms_ready (terms_ready),
        .terms       (terms),
        .flags       (flags)
    );

    wfp_drive u_drive (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .terms_valid (terms_valid),
        .terms_ready (terms_ready),
        .terms       (terms),
        .flags       (flags),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .left_speed  (left_speed),
        .right_speed (right_speed),
        .out_flags   (out_flags)
    );

    assign m_tdata = {3'b000, out_flags.go_straight, out_flags.turn_left,
                      out_flags.turn_right, right_speed, left_speed};

    // Checks
    // Input stalls only when the finished-sum register is full and blocked
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (sum_valid && !sum_ready))
        else $error("s_tready low while sum stage can drain");

    // A blocked average beat stays in place
    assert property (@(posedge aclk) disable iff (!aresetn)
        (avg_valid && !avg_ready) |=> (avg_valid && $stable(avg)))
        else $error("average beat lost under stall");

    // Both speeds stay inside the clamp range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[8:0]) >= -9'sd255 &&
                      $signed(m_tdata[17:9]) >= -9'sd255))
        else $error("speed outside clamp range");

endmodule

@@ rtl/core/wfp_accum.sv @@
// Sample accumulator: sums SAMPLES beats per channel and registers the
// finished sums. Depends on wfp_pkg.
module wfp_accum #(
    parameter int  SAMPLES = wfp_pkg::SAMPLES_DEF,
    localparam int SUM_W   = wfp_pkg::SAMPLE_W + $clog2(SAMPLES)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [wfp_pkg::SAMPLE_W-1:0]  front_sample,
    input  logic [wfp_pkg::SAMPLE_W-1:0]  left_sample,
    input  logic [wfp_pkg::SAMPLE_W-1:0]  right_sample,
    output logic                          sum_valid,
    input  logic                          sum_ready,
    output logic [SUM_W-1:0]              front_sum,
    output logic [SUM_W-1:0]              left_sum,
    output logic [SUM_W-1:0]              right_sum
);
    import wfp_pkg::*;

    localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

    logic [CNT_W-1:0] count_reg;
    logic [SUM_W-1:0] front_acc_reg, left_acc_reg, right_acc_reg;
    logic [SUM_W-1:0] front_next, left_next, right_next;
    logic             sum_vld_reg;
    logic [SUM_W-1:0] front_sum_reg, left_sum_reg, right_sum_reg;
    logic             last_beat;
    logic             accept;

    // Running totals including the current beat
    assign front_next = front_acc_reg + SUM_W'(front_sample);
    assign left_next  = left_acc_reg + SUM_W'(left_sample);
    assign right_next = right_acc_reg + SUM_W'(right_sample);

    assign last_beat = (count_reg == CNT_W'(SAMPLES - 1));
    // Only the closing beat needs room in the sum register
    assign in_ready  = !last_beat || !sum_vld_reg || sum_ready;
    assign accept    = in_valid && in_ready;

    // Accumulator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            front_acc_reg <= '0;
            left_acc_reg  <= '0;
            right_acc_reg <= '0;
        end else if (accept) begin
            if (last_beat) begin
                count_reg     <= '0;
                front_acc_reg <= '0;
                left_acc_reg  <= '0;
                right_acc_reg <= '0;
            end else begin
                count_reg     <= count_reg + CNT_W'(1);
                front_acc_reg <= front_next;
                left_acc_reg  <= left_next;
                right_acc_reg <= right_next;
            end
        end
    end

    // Finished-sum register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_vld_reg <= 1'b0;
        end else if (accept && last_beat) begin
            sum_vld_reg <= 1'b1;
        end else if (sum_ready) begin
            sum_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && last_beat) begin
            front_sum_reg <= front_next;
            left_sum_reg  <= left_next;
            right_sum_reg <= right_next;
        end
    end

    assign sum_valid = sum_vld_reg;
    assign front_sum = front_sum_reg;
    assign left_sum  = left_sum_reg;
    assign right_sum = right_sum_reg;

endmodule

@@ rtl/core/wfp_divide.sv @@
// Averaging stage: divides the three sums by SAMPLES with a reciprocal
// multiply and registers the averages. Depends on wfp_pkg.
module wfp_divide #(
    parameter int  SAMPLES = wfp_pkg::SAMPLES_DEF,
    localparam int SUM_W   = wfp_pkg::SAMPLE_W + $clog2(SAMPLES)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 sum_valid,
    output logic                 sum_ready,
    input  logic [SUM_W-1:0]     front_sum,
    input  logic [SUM_W-1:0]     left_sum,
    input  logic [SUM_W-1:0]     right_sum,
    output logic                 avg_valid,
    input  logic                 avg_ready,
    output wfp_pkg::avg_t        avg
);
    import wfp_pkg::*;

    // Four spare shift bits keep floor(x * RECIP / 2^DIV_SHIFT) exact
    // for every sum up to 2^SUM_W with SAMPLES up to 8.
    localparam int DIV_SHIFT = SUM_W + 4;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((2 ** DIV_SHIFT) + SAMPLES - 1) / SAMPLES);

    logic [PROD_W-1:0] front_prod, left_prod, right_prod;
    logic              avg_vld_reg;
    avg_t              avg_reg;

    assign front_prod = PROD_W'(front_sum) * PROD_W'(RECIP);
    assign left_prod  = PROD_W'(left_sum) * PROD_W'(RECIP);
    assign right_prod = PROD_W'(right_sum) * PROD_W'(RECIP);

    assign sum_ready = !avg_vld_reg || avg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_vld_reg <= 1'b0;
        end else if (sum_ready) begin
            avg_vld_reg <= sum_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_valid && sum_ready) begin
            avg_reg.front <= front_prod[DIV_SHIFT +: SAMPLE_W];
            avg_reg.left  <= left_prod[DIV_SHIFT +: SAMPLE_W];
            avg_reg.right <= right_prod[DIV_SHIFT +: SAMPLE_W];
        end
    end

    assign avg_valid = avg_vld_reg;
    assign avg       = avg_reg;

endmodule

@@ rtl/core/wfp_pid.sv @@
// PID core: steering error, saturating integral, difference term and wall
// flags in one stage, the three gain products in the next. Depends on wfp_pkg.
module wfp_pid (
    input  logic             aclk,
    input  logic             aresetn,
    input  wfp_pkg::cfg_t    cfg,
    input  logic             avg_valid,
    output logic             avg_ready,
    input  wfp_pkg::avg_t    avg,
    output logic             terms_valid,
    input  logic             terms_ready,
    output wfp_pkg::terms_t  terms,
    output wfp_pkg::flags_t  flags
);
    import wfp_pkg::*;

    // Error stage; err_reg also serves as the previous error
    logic                       err_vld_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [INTEG_W-1:0]  integ_reg;
    logic signed [DERR_W-1:0]   derr_reg;
    flags_t                     flags_b_reg;

    logic signed [ERR_W-1:0]    err_c;
    logic signed [INTEG_W:0]    isum;
    logic signed [INTEG_W-1:0]  integ_next;
    logic signed [DERR_W-1:0]   derr_c;
    flags_t                     flags_c;
    logic                       err_ready;
    logic                       err_load;

    // Product stage
    logic                       prod_vld_reg;
    terms_t                     terms_reg;
    flags_t                     flags_reg;
    logic                       prod_ready;

    // left - right + offset, all widened to the error width
    always_comb begin
        err_c = $signed({2'b00, avg.left}) - $signed({2'b00, avg.right})
                + ERR_W'(cfg.error_offset);
        isum  = (INTEG_W + 1)'(integ_reg) + (INTEG_W + 1)'(err_c);
        // clamp to the 24-bit signed range on overflow
        if (isum[INTEG_W] != isum[INTEG_W-1]) begin
            integ_next = {isum[INTEG_W], {(INTEG_W - 1){~isum[INTEG_W]}}};
        end else begin
            integ_next = isum[INTEG_W-1:0];
        end
        derr_c = DERR_W'(err_c) - DERR_W'(err_reg);
    end

    // Wall decisions from the averages
    always_comb begin
        flags_c.turn_right  = (avg.front >= cfg.front_level) &&
                              (avg.right <= cfg.open_level);
        flags_c.turn_left   = (avg.front >= cfg.front_level) &&
                              (avg.left <= cfg.open_level);
        flags_c.go_straight = (avg.right >= cfg.wall_level) &&
                              (avg.left <= cfg.open_level) &&
                              (avg.front <= cfg.open_level);
    end

    assign prod_ready = !prod_vld_reg || terms_ready;
    assign err_ready  = !err_vld_reg || prod_ready;
    assign avg_ready  = err_ready;
    assign err_load   = avg_valid && err_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_vld_reg <= 1'b0;
            err_reg     <= '0;
            integ_reg   <= '0;
        end else begin
            if (err_ready) begin
                err_vld_reg <= avg_valid;
            end
            if (err_load) begin
                err_reg   <= err_c;
                integ_reg <= integ_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (err_load) begin
            derr_reg    <= derr_c;
            flags_b_reg <= flags_c;
        end
    end

    // Gain products, gains taken as non-negative signed values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else if (prod_ready) begin
            prod_vld_reg <= err_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (err_vld_reg && prod_ready) begin
            terms_reg.prop_term  <= PTERM_W'(err_reg) *
                                    PTERM_W'($signed({1'b0, cfg.prop_gain}));
            terms_reg.integ_term <= ITERM_W'(integ_reg) *
                                    ITERM_W'($signed({1'b0, cfg.integ_gain}));
            terms_reg.deriv_term <= DTERM_W'(derr_reg) *
                                    DTERM_W'($signed({1'b0, cfg.deriv_gain}));
            flags_reg            <= flags_b_reg;
        end
    end

    assign terms_valid = prod_vld_reg;
    assign terms       = terms_reg;
    assign flags       = flags_reg;

endmodule

@@ rtl/core/wfp_drive.sv @@
// Motor drive stage: left = base + PID sum, right = base + trim - PID sum;
// truncates toward zero, clamps both speeds, registers the result beat. Depends on wfp_pkg.
module wfp_drive (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  wfp_pkg::cfg_t                     cfg,
    input  logic                              terms_valid,
    output logic                              terms_ready,
    input  wfp_pkg::terms_t                   terms,
    input  wfp_pkg::flags_t                   flags,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [wfp_pkg::SPEED_W-1:0] left_speed,
    output logic signed [wfp_pkg::SPEED_W-1:0] right_speed,
    output wfp_pkg::flags_t                   out_flags
);
    import wfp_pkg::*;

    localparam logic signed [FX_W-1:0] TRIM_FX = FX_W'(RIGHT_TRIM * (2 ** FRAC_W));
    localparam logic signed [Q_W-1:0]  Q_ONE   = Q_W'(1);
    localparam logic signed [Q_W-1:0]  Q_MAX   = Q_W'(SPEED_LIMIT);
    localparam logic signed [Q_W-1:0]  Q_MIN   = -Q_W'(SPEED_LIMIT);

    // Fixed-point value to integer speed: truncate toward zero, then clamp
    function automatic logic signed [SPEED_W-1:0] speed_sat(
        input logic signed [FX_W-1:0] fx
    );
        logic signed [Q_W-1:0] q;
        logic signed [Q_W-1:0] t;
        q = $signed(fx[FX_W-1:FRAC_W]);
        t = (fx[FX_W-1] && (fx[FRAC_W-1:0] != '0)) ? q + Q_ONE : q;
        if (t > Q_MAX) begin
            t = Q_MAX;
        end else if (t < Q_MIN) begin
            t = Q_MIN;
        end
        return SPEED_W'(t);
    endfunction

    logic signed [FX_W-1:0]    pid;
    logic signed [FX_W-1:0]    base_fx;
    logic signed [FX_W-1:0]    left_fx;
    logic signed [FX_W-1:0]    right_fx;
    logic                      out_vld_reg;
    logic signed [SPEED_W-1:0] left_speed_reg;
    logic signed [SPEED_W-1:0] right_speed_reg;
    flags_t                    flags_reg;

    assign pid     = FX_W'(terms.prop_term) + FX_W'(terms.integ_term)
                     + FX_W'(terms.deriv_term);
    assign base_fx = $signed({Q_W'(cfg.base_speed), {FRAC_W{1'b0}}});
    assign left_fx  = base_fx + pid;
    assign right_fx = base_fx + TRIM_FX - pid;

    assign terms_ready = !out_vld_reg || out_ready;

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (terms_ready) begin
            out_vld_reg <= terms_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (terms_valid && terms_ready) begin
            left_speed_reg  <= speed_sat(left_fx);
            right_speed_reg <= speed_sat(right_fx);
            flags_reg       <= flags;
        end
    end

    assign out_valid   = out_vld_reg;
    assign left_speed  = left_speed_reg;
    assign right_speed = right_speed_reg;
    assign out_flags   = flags_reg;

endmodule
